// ===== rtl/assert_macros.svh =====
// assertion macros shared by the sweep sequencer rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge out of reset
`define LES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence checked in the cycle after the antecedent
`define LES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/les_pkg.sv =====
// types and constants of the line endpoint sweep sequencer
// no dependencies
package les_pkg;

  localparam int OUT_COORD_W = 12;
  localparam int COLOR_W     = 8;
  localparam int PAL_W       = 9;
  localparam int DIV_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [OUT_COORD_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [OUT_COORD_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [PAL_W-1:0]       PALETTE_SIZE_RST = 9'd256;
  localparam logic [DIV_W-1:0]       TICK_DIVIDER_RST = 16'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PALETTE_SIZE = 2'd2,
    REG_TICK_DIVIDER = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_0 = 2'd0,
    MODE_1 = 2'd1,
    MODE_2 = 2'd2
  } sweep_mode_t;

  typedef enum logic [2:0] {
    PH_0 = 3'd0,
    PH_1 = 3'd1,
    PH_2 = 3'd2,
    PH_3 = 3'd3,
    PH_4 = 3'd4,
    PH_5 = 3'd5,
    PH_6 = 3'd6,
    PH_7 = 3'd7
  } phase_t;

  typedef struct packed {
    logic pause;
    logic redraw_request;
    logic mode_advance;
  } in_item_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] line_start_x;
    logic [OUT_COORD_W-1:0] line_start_y;
    logic [OUT_COORD_W-1:0] line_end_x;
    logic [OUT_COORD_W-1:0] line_end_y;
    logic [COLOR_W-1:0]     color_index;
    logic                   clear_screen;
  } out_item_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] frame_width;
    logic [OUT_COORD_W-1:0] frame_height;
    logic [PAL_W-1:0]       palette_size;
    logic [DIV_W-1:0]       tick_divider;
  } cfg_t;

  typedef struct packed {
    logic     fire;
    in_item_t item;
  } stage_ctrl_t;

  typedef struct packed {
    logic      step;
    out_item_t item;
  } res_t;

endpackage

// ===== rtl/les_in_if.sv =====
// tick input channel of the sweep sequencer
// depends on les_pkg
interface les_in_if;
  import les_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/les_out_if.sv =====
// line result channel of the sweep sequencer
// depends on les_pkg
interface les_out_if;
  import les_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/les_cfg_if.sv =====
// configuration write channel of the sweep sequencer
// depends on les_pkg
interface les_cfg_if;
  import les_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/les_cfg_regs.sv =====
// configuration registers of the sweep sequencer
// depends on les_pkg and les_cfg_if
module les_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  les_cfg_if.sink       cfg_ch,
  output les_pkg::cfg_t cfg
);
  import les_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_ch.data[OUT_COORD_W-1:0];
        REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_ch.data[OUT_COORD_W-1:0];
        REG_PALETTE_SIZE: cfg_nxt.palette_size = cfg_ch.data[PAL_W-1:0];
        REG_TICK_DIVIDER: cfg_nxt.tick_divider = cfg_ch.data[DIV_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= FRAME_WIDTH_RST;
      cfg_r.frame_height <= FRAME_HEIGHT_RST;
      cfg_r.palette_size <= PALETTE_SIZE_RST;
      cfg_r.tick_divider <= TICK_DIVIDER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/les_in_stage.sv =====
// input register of the sweep sequencer, holds one tick until it is processed
// depends on les_pkg, les_in_if and assert_macros.svh
`include "assert_macros.svh"

module les_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  les_in_if.sink               in_ch,
  input  logic                 out_free,
  output les_pkg::stage_ctrl_t s1
);
  import les_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     fire;
  logic     take;

  assign fire        = valid_r && out_free;
  assign in_ch.ready = !valid_r || out_free;
  assign take        = in_ch.valid && in_ch.ready;
  assign s1.fire     = fire;
  assign s1.item     = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_ch.data;
    end
  end

  // a held tick stays in place while the result side is blocked
  `LES_ASSERT_NEXT(a_hold_blocked, valid_r && !out_free, valid_r && $stable(item_r), "tick lost while blocked")

endmodule

// ===== rtl/les_sweep_core.sv =====
// sweep state and single-pass step logic: prescaler, requests, mode, phase,
// endpoints and palette cursor; depends on les_pkg and assert_macros.svh
`include "assert_macros.svh"

module les_sweep_core #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  les_pkg::cfg_t        cfg,
  input  les_pkg::stage_ctrl_t s1,
  output les_pkg::res_t        res
);
  import les_pkg::*;

  localparam int CMP_W = (COORD_WIDTH > OUT_COORD_W) ? COORD_WIDTH : OUT_COORD_W;

  logic [DIV_W-1:0]       prescale_r, prescale_nxt;
  logic                   redraw_pend_r, redraw_pend_nxt;
  logic                   adv_pend_r, adv_pend_nxt;
  sweep_mode_t            mode_r, mode_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [COORD_WIDTH-1:0] ax_r, ay_r, bx_r, by_r;
  logic [COORD_WIDTH-1:0] ax_nxt, ay_nxt, bx_nxt, by_nxt;
  logic [COLOR_W-1:0]     cursor_r, cursor_nxt;

  logic                   live;
  logic [DIV_W:0]         cnt_inc;
  logic                   step;
  logic                   rp;
  logic                   ap;
  sweep_mode_t            mode_c;
  sweep_mode_t            mode_up;
  phase_t                 phase_c;
  logic [COORD_WIDTH-1:0] ax_c, ay_c, bx_c, by_c;
  logic [COORD_WIDTH-1:0] ax_i, ay_i, bx_i, by_i;
  logic [COORD_WIDTH-1:0] ax_d, ay_d, bx_d, by_d;
  logic                   ax_z, ay_z, bx_z, by_z;
  logic                   ax_hit, ay_hit, bx_hit, by_hit;
  logic [PAL_W-1:0]       cur_inc;

  // tick qualification and requests
  assign live    = s1.fire && !s1.item.pause;
  assign cnt_inc = (DIV_W + 1)'(prescale_r) + 1'b1;
  assign step    = live && (cnt_inc >= (DIV_W + 1)'(cfg.tick_divider));
  assign rp      = redraw_pend_r || s1.item.redraw_request;
  assign ap      = adv_pend_r || s1.item.mode_advance;

  always_comb begin
    case (mode_r)
      MODE_0:  mode_up = MODE_1;
      MODE_1:  mode_up = MODE_2;
      default: mode_up = MODE_0;
    endcase
  end

  assign mode_c  = ap ? mode_up : mode_r;
  assign phase_c = rp ? PH_0 : phase_r;
  assign ax_c    = rp ? '0 : ax_r;
  assign ay_c    = rp ? '0 : ay_r;
  assign bx_c    = rp ? COORD_WIDTH'(cfg.frame_width) : bx_r;
  assign by_c    = rp ? '0 : by_r;

  // one-pixel neighbors and edge tests of every coordinate
  assign ax_i   = ax_c + 1'b1;
  assign ay_i   = ay_c + 1'b1;
  assign bx_i   = bx_c + 1'b1;
  assign by_i   = by_c + 1'b1;
  assign ax_d   = ax_c - 1'b1;
  assign ay_d   = ay_c - 1'b1;
  assign bx_d   = bx_c - 1'b1;
  assign by_d   = by_c - 1'b1;
  assign ax_z   = (ax_c == '0);
  assign ay_z   = (ay_c == '0);
  assign bx_z   = (bx_c == '0);
  assign by_z   = (by_c == '0);
  assign ax_hit = CMP_W'(ax_i) >= CMP_W'(cfg.frame_width);
  assign ay_hit = CMP_W'(ay_i) >= CMP_W'(cfg.frame_height);
  assign bx_hit = CMP_W'(bx_i) >= CMP_W'(cfg.frame_width);
  assign by_hit = CMP_W'(by_i) >= CMP_W'(cfg.frame_height);

  assign cur_inc = PAL_W'(cursor_r) + 1'b1;

  // result of this tick, shown before the endpoints move
  assign res.step              = step;
  assign res.item.line_start_x = OUT_COORD_W'(ax_c);
  assign res.item.line_start_y = OUT_COORD_W'(ay_c);
  assign res.item.line_end_x   = OUT_COORD_W'(bx_c);
  assign res.item.line_end_y   = OUT_COORD_W'(by_c);
  assign res.item.color_index  = cursor_r;
  assign res.item.clear_screen = rp;

  always_comb begin
    prescale_nxt    = prescale_r;
    redraw_pend_nxt = redraw_pend_r;
    adv_pend_nxt    = adv_pend_r;
    mode_nxt        = mode_r;
    phase_nxt       = phase_r;
    ax_nxt          = ax_r;
    ay_nxt          = ay_r;
    bx_nxt          = bx_r;
    by_nxt          = by_r;
    cursor_nxt      = cursor_r;
    if (step) begin
      prescale_nxt    = '0;
      redraw_pend_nxt = 1'b0;
      adv_pend_nxt    = 1'b0;
      mode_nxt        = mode_c;
      phase_nxt       = phase_c;
      ax_nxt          = ax_c;
      ay_nxt          = ay_c;
      bx_nxt          = bx_c;
      by_nxt          = by_c;
      if ((cur_inc >= cfg.palette_size) || cur_inc[PAL_W-1]) begin
        cursor_nxt = '0;
      end else begin
        cursor_nxt = cur_inc[COLOR_W-1:0];
      end
      case (mode_c)
        MODE_0: begin
          case (phase_c)
            PH_0: begin
              by_nxt = by_i;
              if (by_hit) phase_nxt = PH_1;
            end
            PH_1: begin
              ax_nxt = ax_i;
              if (ax_hit) phase_nxt = PH_2;
            end
            PH_2: begin
              if (bx_z) phase_nxt = PH_3;
              else bx_nxt = bx_d;
            end
            PH_3: begin
              ay_nxt = ay_i;
              if (ay_hit) phase_nxt = PH_4;
            end
            PH_4: begin
              if (by_z) phase_nxt = PH_5;
              else by_nxt = by_d;
            end
            PH_5: begin
              if (ax_z) phase_nxt = PH_6;
              else ax_nxt = ax_d;
            end
            PH_6: begin
              bx_nxt = bx_i;
              if (bx_hit) phase_nxt = PH_7;
            end
            default: begin
              if (ay_z) phase_nxt = PH_0;
              else ay_nxt = ay_d;
            end
          endcase
        end
        MODE_1: begin
          case (phase_c)
            PH_0: begin
              by_nxt = by_i;
              if (by_hit) phase_nxt = PH_1;
            end
            PH_1: begin
              if (bx_z) phase_nxt = PH_2;
              else bx_nxt = bx_d;
            end
            PH_2: begin
              ax_nxt = ax_i;
              if (ax_hit) phase_nxt = PH_3;
            end
            PH_3: begin
              ay_nxt = ay_i;
              if (ay_hit) phase_nxt = PH_4;
            end
            PH_4: begin
              if (by_z) phase_nxt = PH_5;
              else by_nxt = by_d;
            end
            PH_5: begin
              bx_nxt = bx_i;
              if (bx_hit) phase_nxt = PH_6;
            end
            PH_6: begin
              if (ax_z) phase_nxt = PH_7;
              else ax_nxt = ax_d;
            end
            default: begin
              if (ay_z) phase_nxt = PH_0;
              else ay_nxt = ay_d;
            end
          endcase
        end
        default: begin
          case (phase_c)
            PH_0: begin
              by_nxt = by_i;
              if (by_hit) phase_nxt = PH_1;
            end
            PH_1: begin
              ax_nxt = ax_i;
              if (ax_hit) begin
                phase_nxt = PH_2;
                bx_nxt    = '0;
              end else begin
                bx_nxt = bx_d;
              end
            end
            PH_2: begin
              ay_nxt = ay_i;
              if (ay_hit) begin
                phase_nxt = PH_3;
                by_nxt    = '0;
              end else begin
                by_nxt = by_d;
              end
            end
            PH_3: begin
              if (ax_z) begin
                phase_nxt = PH_4;
              end else begin
                ax_nxt = ax_d;
                bx_nxt = bx_i;
              end
            end
            PH_4: begin
              if (ay_z) begin
                phase_nxt = PH_1;
              end else begin
                ay_nxt = ay_d;
                by_nxt = by_i;
              end
            end
            // phases without meaning here hold still until a redraw or a mode advance
            default: phase_nxt = phase_c;
          endcase
        end
      endcase
    end else if (live) begin
      prescale_nxt    = cnt_inc[DIV_W-1:0];
      redraw_pend_nxt = rp;
      adv_pend_nxt    = ap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r    <= '0;
      redraw_pend_r <= 1'b0;
      adv_pend_r    <= 1'b0;
      mode_r        <= MODE_0;
      phase_r       <= PH_0;
      ax_r          <= '0;
      ay_r          <= '0;
      bx_r          <= '0;
      by_r          <= '0;
      cursor_r      <= '0;
    end else begin
      prescale_r    <= prescale_nxt;
      redraw_pend_r <= redraw_pend_nxt;
      adv_pend_r    <= adv_pend_nxt;
      mode_r        <= mode_nxt;
      phase_r       <= phase_nxt;
      ax_r          <= ax_nxt;
      ay_r          <= ay_nxt;
      bx_r          <= bx_nxt;
      by_r          <= by_nxt;
      cursor_r      <= cursor_nxt;
    end
  end

  // an animation step consumes both requests and restarts the prescaler
  `LES_ASSERT_NEXT(a_step_clears, step, (prescale_r == '0) && !redraw_pend_r && !adv_pend_r, "step left requests or count behind")
  // nothing moves without a processed tick
  `LES_ASSERT_NEXT(a_idle_holds, !s1.fire, $stable(prescale_r) && $stable(mode_r) && $stable(phase_r) && $stable(cursor_r), "state changed without a tick")

endmodule

// ===== rtl/les_out_stage.sv =====
// result register of the sweep sequencer
// depends on les_pkg and les_out_if
module les_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  les_pkg::res_t res,
  input  logic          fire,
  les_out_if.source     out_ch,
  output logic          out_free
);
  import les_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;
  logic      load;

  assign out_free     = !valid_r || out_ch.ready;
  assign load         = fire && res.step;
  assign out_ch.valid = valid_r;
  assign out_ch.data  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res.item;
    end
  end

endmodule

// ===== rtl/line_endpoint_sweep_sequencer.sv =====
// Line endpoint sweep sequencer. Each tick transfer on in_ch is taken into an
// input register and processed by the sweep core: paused ticks are dropped, others
// latch redraw and mode-advance requests and count the prescaler; every
// tick_divider-th unpaused tick produces one line transfer on out_ch with both
// endpoints, the palette index and the clear flag, then steps the endpoints
// one pixel along the frame edges. One tick is accepted per clock while the
// result register can take a line; each line is computed from the tick in the
// input register and loaded into the result register, and both registers keep
// flowing while out_ch stalls until the result register is full. Configuration
// writes on cfg_ch are registered and always ready. No clearing pass after reset.
// depends on les_pkg, the channel interfaces and all les_ modules
module line_endpoint_sweep_sequencer #(
  parameter int COORD_WIDTH = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  les_in_if.sink    in_ch,
  les_out_if.source out_ch,
  les_cfg_if.sink   cfg_ch
);
  import les_pkg::*;

  cfg_t        cfg;
  stage_ctrl_t s1;
  res_t        res;
  logic        out_free;

  les_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  les_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .s1       (s1)
  );

  les_sweep_core #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_sweep_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .s1    (s1),
    .res   (res)
  );

  les_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .fire     (s1.fire),
    .out_ch   (out_ch),
    .out_free (out_free)
  );

endmodule
